// File: rtl/page_frame_bitmap_allocator_unit_macros.svh
// assertion macros for the page frame bitmap allocator
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
// clocked implication check, disabled in reset
`define PFBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication check, disabled in reset
`define PFBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/pfba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfba_pkg
// types and constants shared by the page frame bitmap allocator
// ----------------------------------------------------------------------------
package pfba_pkg;
    localparam logic [2:0] CMD_ALLOC     = 3'd0;
    localparam logic [2:0] CMD_FREE_HINT = 3'd1;
    localparam logic [2:0] CMD_MARK_USED = 3'd2;
    localparam logic [2:0] CMD_MARK_FREE = 3'd3;
    localparam logic [2:0] CMD_FILL_ALL  = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_MEM = 2'd1;
    localparam logic [1:0] ST_INVAL  = 2'd2;

    localparam int PAGE_W  = 16;
    localparam int COUNT_W = 17;
    localparam int CFG_W   = 14;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [PAGE_W-1:0]  start_page;
        logic [COUNT_W-1:0] page_count;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [PAGE_W-1:0]  found_page;
        logic [COUNT_W-1:0] granted_pages;
    } t_rsp;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_WR_RD, S_WR_MOD, S_FILL, S_RESP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture request
        logic clr_init;   // start clear / fill sweep
        logic clr_step;   // write 0xff at sweep address, advance
        logic scan_init;  // start allocation scan
        logic scan_rd;    // issue read at scan address
        logic scan_chk;   // evaluate scan byte
        logic wr_init;    // start range write
        logic wr_rd;      // issue read at range byte
        logic wr_mod;     // write back modified byte, advance
        logic rsp_load;   // build result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic scan_done;
        logic scan_fail;
        logic wr_done;
        logic is_alloc;
        logic is_range;
        logic is_fill;
        logic bad;
    } t_stat;
endpackage

// File: rtl/pfba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfba_ctrl
// sequencer for clear, scan, range write and result transfer
// ----------------------------------------------------------------------------
`include "page_frame_bitmap_allocator_unit_macros.svh"
module pfba_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  pfba_pkg::t_stat i_stat,
    output pfba_pkg::t_cmd  o_cmd
);
    import pfba_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:    if (i_stat.clr_last) n_state = S_IDLE;
            S_IDLE: begin
                if (i_in_valid) n_state = S_SCAN_RD;
            end
            S_SCAN_RD:  n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (i_stat.scan_fail) n_state = S_RESP;
                else if (i_stat.scan_done) n_state = S_WR_RD;
                else n_state = S_SCAN_RD;
            end
            S_WR_RD:    n_state = i_stat.wr_done ? S_RESP : S_WR_MOD;
            S_WR_MOD:   n_state = S_WR_RD;
            S_FILL:     if (i_stat.clr_last) n_state = S_RESP;
            S_RESP: begin
                if (!(r_out_valid && i_out_stall)) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
        // dispatch after load: scan state reused as decode slot
        if (r_state == S_SCAN_RD && r_first) begin
            if (i_stat.is_alloc) n_state = i_stat.bad ? S_RESP : S_SCAN_RD;
            else if (i_stat.is_range) n_state = S_WR_RD;
            else if (i_stat.is_fill) n_state = S_FILL;
            else n_state = S_RESP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_first <= 1'b1;
        else if (r_state == S_IDLE) r_first <= 1'b1;
        else if (r_state == S_SCAN_RD) r_first <= 1'b0;
    end

    always_comb begin
        o_cmd = '0;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_CLEAR:    o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                if (i_in_valid) o_cmd.load = 1'b1;
            end
            S_SCAN_RD: begin
                if (r_first) begin
                    o_cmd.scan_init = i_stat.is_alloc;
                    o_cmd.wr_init   = i_stat.is_range;
                    o_cmd.clr_init  = i_stat.is_fill;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                end
            end
            S_SCAN_CHK: o_cmd.scan_chk = 1'b1;
            S_WR_RD:    o_cmd.wr_rd = 1'b1;
            S_WR_MOD:   o_cmd.wr_mod = 1'b1;
            S_FILL:     o_cmd.clr_step = 1'b1;
            S_RESP: begin
                if (!(r_out_valid && i_out_stall)) begin
                    o_cmd.rsp_load = 1'b1;
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `PFBA_ASSERT_IMP(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0(o_cmd), "two commands at once")
    `PFBA_ASSERT_NXT(a_resp_valid, i_clk, i_rst_n, o_cmd.rsp_load, r_out_valid, "result lost")
    `PFBA_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall, "taken busy")
endmodule

// File: rtl/pfba_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfba_dpath
// bitmap memory, hint, scan and range write datapath
// ----------------------------------------------------------------------------
module pfba_dpath #(
    parameter int BITMAP_BYTES = 8192
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pfba_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  pfba_pkg::t_req                  i_req,
    input  pfba_pkg::t_cmd                  i_cmd,
    output pfba_pkg::t_stat                 o_stat,
    output pfba_pkg::t_rsp                  o_rsp
);
    import pfba_pkg::*;

    localparam int AW    = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int PW    = AW + 3;
    localparam int WW    = (PW > COUNT_W + 1 ? PW : COUNT_W + 1) + 1;
    localparam logic [WW-1:0] TOTAL = WW'(BITMAP_BYTES) << 3;

    logic [7:0] r_mem [BITMAP_BYTES];
    logic [7:0] r_rd;

    logic [CFG_W-1:0]   r_cfg;
    logic [COUNT_W-1:0] r_hint;
    t_req               r_req;
    t_rsp               r_rsp, n_rsp;
    logic [AW:0]        r_clr_addr;
    logic [WW-1:0]      r_p, r_run_start, r_run_len, r_end, r_limit;
    logic               r_fail, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg  <= CFG_W'(8192);
            r_hint <= '0;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
            if (i_cmd.load && i_req.cmd == CMD_FREE_HINT
                && COUNT_W'(i_req.start_page) < r_hint)
                r_hint <= COUNT_W'(i_req.start_page);
            if (i_cmd.scan_chk && r_done && !r_fail) r_hint <= COUNT_W'(r_p);
        end
    end

    // scan evaluation on one page per check cycle
    logic [WW-1:0] w_page_p;
    logic          w_used;
    assign w_used = (r_p >= TOTAL) ? 1'b1 : r_rd[3'd7 - r_p[2:0]];

    logic [WW-1:0] w_bytes;
    assign w_bytes = (WW'(r_cfg) > WW'(BITMAP_BYTES)) ? WW'(BITMAP_BYTES) : WW'(r_cfg);

    logic [WW-1:0] w_p_next, w_rs_next, w_rl_next;
    logic          w_hit;
    always_comb begin
        w_p_next  = r_p + WW'(1);
        w_rs_next = w_used ? w_p_next : r_run_start;
        w_rl_next = w_used ? '0 : r_run_len + WW'(1);
        w_hit     = !w_used && (w_rl_next == WW'(r_req.page_count));
    end
    assign w_page_p = r_p;

    logic [WW-1:0] w_wr_next, w_byte_end;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_req;
        if (i_cmd.scan_init) begin
            r_p         <= WW'(r_hint);
            r_run_start <= WW'(r_hint);
            r_run_len   <= '0;
            r_limit     <= w_bytes << 3;
            r_done      <= 1'b0;
            r_fail      <= (WW'(r_hint) >= (w_bytes << 3));
        end
        if (i_cmd.scan_chk && !r_done && !r_fail) begin
            r_p         <= w_p_next;
            r_run_start <= w_rs_next;
            r_run_len   <= w_rl_next;
            if (w_hit) r_done <= 1'b1;
            else if (w_p_next >= r_limit) r_fail <= 1'b1;
        end
        if (i_cmd.scan_chk && r_done && !r_fail) begin
            r_p   <= r_run_start;
            r_end <= ((r_run_start + WW'(r_req.page_count)) > TOTAL) ? TOTAL
                     : r_run_start + WW'(r_req.page_count);
        end
        if (i_cmd.wr_init) begin
            r_p   <= WW'(r_req.start_page);
            r_end <= ((WW'(r_req.start_page) + WW'(r_req.page_count)) > TOTAL) ? TOTAL
                     : WW'(r_req.start_page) + WW'(r_req.page_count);
        end
        if (i_cmd.wr_mod) r_p <= w_wr_next;
    end

    // range write: one byte per group, bits [p, min(end, byte end))
    logic [7:0]    w_mask;
    logic          w_set;
    always_comb begin
        w_byte_end = {r_p[WW-1:3], 3'b000} + WW'(8);
        w_wr_next  = (w_byte_end < r_end) ? w_byte_end : r_end;
        w_set      = (r_req.cmd == CMD_ALLOC) || (r_req.cmd == CMD_MARK_USED);
        for (int b = 0; b < 8; b++) begin
            w_mask[7-b] = ({r_p[WW-1:3], 3'(b)} >= r_p)
                       && ({r_p[WW-1:3], 3'(b)} < r_end);
        end
    end

    // memory: one write or one read per cycle
    logic [AW-1:0] w_rd_addr;
    assign w_rd_addr = r_p[AW+2:3];

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) r_mem[r_clr_addr[AW-1:0]] <= 8'hff;
        else if (i_cmd.wr_mod)
            r_mem[w_rd_addr] <= w_set ? (r_rd | w_mask) : (r_rd & ~w_mask);
        if (i_cmd.scan_rd || i_cmd.wr_rd) r_rd <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr_addr <= '0;
        else if (i_cmd.clr_init) r_clr_addr <= '0;
        else if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + (AW+1)'(1);
    end

    always_comb begin
        n_rsp = '0;
        if (r_req.cmd == CMD_ALLOC) begin
            if (r_req.page_count == '0) n_rsp.status = ST_INVAL;
            else if (r_fail) n_rsp.status = ST_NO_MEM;
            else begin
                n_rsp.found_page    = r_run_start[PAGE_W-1:0];
                n_rsp.granted_pages = r_req.page_count;
            end
        end else if (r_req.cmd > CMD_FILL_ALL) n_rsp.status = ST_INVAL;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rsp_load) r_rsp <= n_rsp;
    end

    assign o_stat.clr_last  = (r_clr_addr == (AW+1)'(BITMAP_BYTES - 1));
    assign o_stat.scan_done = r_done;
    assign o_stat.scan_fail = r_fail;
    assign o_stat.wr_done   = (r_p >= r_end) || (w_page_p >= TOTAL);
    assign o_stat.is_alloc  = (r_req.cmd == CMD_ALLOC);
    assign o_stat.is_range  = (r_req.cmd == CMD_FREE_HINT) || (r_req.cmd == CMD_MARK_USED)
                           || (r_req.cmd == CMD_MARK_FREE);
    assign o_stat.is_fill   = (r_req.cmd == CMD_FILL_ALL);
    assign o_stat.bad       = (r_req.page_count == '0);
    assign o_rsp = r_rsp;
endmodule

// File: rtl/page_frame_bitmap_allocator_unit.sv
`timescale 1ns / 1ps
// allocate: scans pages from the hint, then writes each bitmap byte of the found run
// free and mark: read-modify-write of each bitmap byte the range touches
// fill all used: one cycle per bitmap byte, single memory write port
// one item in flight plus one result held in the output register
// after reset a clearing pass over all BITMAP_BYTES bytes sets all pages used
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_unit
// bitmap page frame allocator with next-fit hint
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator_unit #(
    parameter int BITMAP_BYTES = 8192
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pfba_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  pfba_pkg::t_req             i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output pfba_pkg::t_rsp             o_out_data
);
    import pfba_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    pfba_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    pfba_dpath #(.BITMAP_BYTES(BITMAP_BYTES)) u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_req(i_in_data), .i_cmd(w_cmd),
        .o_stat(w_stat), .o_rsp(o_out_data)
    );
endmodule
